// ===== sv/iaf_pkg.sv =====
// Shared types, codes and character constants for the integer to ASCII formatter.
// Used by the top level, the digit unit and the port checker; depends on nothing.
package iaf_pkg;

   // Width of the value field on the request channel
   localparam int VALUE_FIELD_BITS = 32;

   // Format codes carried in the action field
   localparam logic [1:0] ACT_UNSIGNED_DEC = 2'd0;
   localparam logic [1:0] ACT_SIGNED_DEC   = 2'd1;
   localparam logic [1:0] ACT_HEX          = 2'd2;

   // ASCII characters used by the formatter
   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_NINE  = 7'h39;
   localparam logic [6:0] CHAR_A     = 7'h41;
   localparam logic [6:0] CHAR_F     = 7'h46;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;

   // Radix of decimal digits
   localparam logic [3:0] DEC_RADIX = 4'd10;

   // One request item
   typedef struct packed {
      logic [VALUE_FIELD_BITS-1:0] value;
      logic [1:0]                  action;
   } iaf_req_type;

   // One result item: a single character
   typedef struct packed {
      logic [6:0] ascii_char;
      logic       last;
   } iaf_rsp_type;

   // Operations of the shared digit unit
   typedef enum logic [1:0] {
      DOP_HOLD   = 2'd0,
      DOP_LOAD   = 2'd1,
      DOP_DABBLE = 2'd2,
      DOP_SHIFT  = 2'd3
   } iaf_dop_type;

   // Control from the sequencer to the digit unit
   typedef struct packed {
      iaf_dop_type op;
      logic        bit_in;
   } iaf_dctl_type;

   // Map one digit value to its upper-case ASCII character
   function automatic logic [6:0] nib_to_ascii(input logic [3:0] nib);
      logic [6:0] ch;
      if (nib < DEC_RADIX) begin
         ch = CHAR_ZERO + {3'b000, nib};
      end else begin
         ch = CHAR_A + {3'b000, nib - DEC_RADIX};
      end
      return ch;
   endfunction

endpackage

// ===== sv/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter: sequencer, binary shifter and output register.
// Depends on iaf_pkg and iaf_digit_unit.
//
// Usage: the req_ channel takes one item holding a value and a format code
// (unsigned decimal, signed decimal, upper-case hex; code 3 acts as hex).
// The rsp_ channel returns the number as ASCII characters, most significant
// first, leading zeros dropped, with last set on the final character.
// Negative signed values start with a minus sign.
// Decimal values go through one double-dabble step per value bit in the
// shared digit unit; hex values load straight into the digit register.
// The sequencer then drops one leading zero digit per cycle and sends one
// character per cycle while the receiver is ready.
// The digit register holds DIGITS digits, where DIGITS is the decimal width
// of VALUE_BITS (10 at 32 bits).
// req_ready is high only while the block is idle; it may accept the next
// item while the final character still waits in the output register.
// When the receiver stalls, the output register holds its character and
// the sequencer waits. Synchronous reset returns the block to idle and
// drops any pending character.
module integer_to_ascii_formatter
   import iaf_pkg::*;
#(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  iaf_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output iaf_rsp_type rsp_data
);

   localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int DW     = DIGITS * 4;
   localparam int BW     = $clog2(VALUE_BITS + 1);
   localparam int CW     = $clog2(DIGITS + 1);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CONV = 5'b00010,
      ST_SKIP = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] bin_ff, bin_in;
   logic                  neg_ff, neg_in;
   logic [BW-1:0]         bits_ff, bits_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   iaf_rsp_type           rsp_ff, rsp_in;

   logic [VALUE_BITS-1:0] val;
   logic [VALUE_BITS-1:0] mag;
   logic                  neg;
   logic                  out_free;
   iaf_dctl_type          dctl;
   logic [DW-1:0]         load_data;
   logic [3:0]            top_digit;

   // Fit the value field to the configured width
   if (VALUE_BITS <= VALUE_FIELD_BITS) begin : g_trunc
      assign val = req_data.value[VALUE_BITS-1:0];
   end else begin : g_ext
      assign val = {{(VALUE_BITS-VALUE_FIELD_BITS){1'b0}}, req_data.value};
   end

   // Take the magnitude of a negative signed value
   assign neg = (req_data.action == ACT_SIGNED_DEC) && val[VALUE_BITS-1];
   assign mag = neg ? (~val + VALUE_BITS'(1)) : val;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   iaf_digit_unit #(
      .DIGITS(DIGITS)
   ) u_digits (
      .clock     (clock),
      .ctl       (dctl),
      .load_data (load_data),
      .top_digit (top_digit)
   );

   // Sequence conversion, zero skipping and character output
   always_comb begin
      state_in     = state_ff;
      bin_in       = bin_ff;
      neg_in       = neg_ff;
      bits_in      = bits_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      dctl.op      = DOP_HOLD;
      dctl.bit_in  = 1'b0;
      load_data    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               bin_in  = mag;
               neg_in  = neg;
               dctl.op = DOP_LOAD;
               if (req_data.action[1]) begin
                  // hex digits are the value's nibbles as they stand
                  load_data = {{(DW-VALUE_BITS){1'b0}}, val};
                  cnt_in    = CW'(DIGITS);
                  state_in  = ST_SKIP;
               end else begin
                  bits_in  = BW'(VALUE_BITS);
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            dctl.op     = DOP_DABBLE;
            dctl.bit_in = bin_ff[VALUE_BITS-1];
            bin_in      = {bin_ff[VALUE_BITS-2:0], 1'b0};
            bits_in     = bits_ff - 1'b1;
            if (bits_ff == BW'(1)) begin
               cnt_in   = CW'(DIGITS);
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            // drop leading zeros, keeping at least one digit
            if (top_digit == 4'h0 && cnt_ff != CW'(1)) begin
               dctl.op = DOP_SHIFT;
               cnt_in  = cnt_ff - 1'b1;
            end else if (neg_ff) begin
               state_in = ST_SIGN;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.ascii_char = CHAR_MINUS;
               rsp_in.last       = 1'b0;
               state_in          = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.ascii_char = nib_to_ascii(top_digit);
               rsp_in.last       = (cnt_ff == CW'(1));
               dctl.op           = DOP_SHIFT;
               cnt_in            = cnt_ff - 1'b1;
               if (cnt_ff == CW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      bin_ff  <= bin_in;
      neg_ff  <= neg_in;
      bits_ff <= bits_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/iaf_digit_unit.sv =====
// Digit register with the shared double-dabble step and nibble shifter.
// Depends on iaf_pkg for the control struct and operation codes.
module iaf_digit_unit
   import iaf_pkg::*;
#(
   parameter int DIGITS = 10
) (
   input  logic                  clock,
   input  iaf_dctl_type          ctl,
   input  logic [DIGITS*4-1:0]   load_data,
   output logic [3:0]            top_digit
);

   localparam int DW = DIGITS * 4;

   logic [DW-1:0] digits_ff;
   logic [DW-1:0] digits_in;
   logic [DW-1:0] adjusted;

   // Add three to every digit of five or more before the shift
   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (digits_ff[i*4 +: 4] >= 4'd5) begin
            adjusted[i*4 +: 4] = digits_ff[i*4 +: 4] + 4'd3;
         end else begin
            adjusted[i*4 +: 4] = digits_ff[i*4 +: 4];
         end
      end
   end

   // Select the next digit register contents
   always_comb begin
      unique case (ctl.op)
         DOP_LOAD:   digits_in = load_data;
         DOP_DABBLE: digits_in = {adjusted[DW-2:0], ctl.bit_in};
         DOP_SHIFT:  digits_in = {digits_ff[DW-5:0], 4'h0};
         default:    digits_in = digits_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
   end

   assign top_digit = digits_ff[DW-1 -: 4];

endmodule

// ===== sv/iaf_checker.sv =====
// Port-level checks for the integer to ASCII formatter, bound to the top level.
// Depends on iaf_pkg and integer_to_ascii_formatter.
module iaf_checker
   import iaf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input iaf_req_type req_data,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input iaf_rsp_type rsp_data
);

   // Hold a stalled character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled character changed or dropped");

   // Stay busy for the cycle after an item is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted in back-to-back cycles");

   // Emit only digits, A to F, or a minus sign
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data.ascii_char >= CHAR_ZERO && rsp_data.ascii_char <= CHAR_NINE)
                  || (rsp_data.ascii_char >= CHAR_A && rsp_data.ascii_char <= CHAR_F)
                  || (rsp_data.ascii_char == CHAR_MINUS)))
      else $error("character outside the output set");

   // A minus sign is never the final character
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ascii_char == CHAR_MINUS |-> !rsp_data.last)
      else $error("minus sign flagged as last");

   // Come out of reset idle with nothing pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind integer_to_ascii_formatter iaf_checker u_iaf_checker (.*);
